FILE: src/gcchg_pkg.sv
// Shared widths, register indexes and types for the greedy coin change block.
package gcchg_pkg;

  localparam int MAX_COINS     = 6;
  localparam int AMOUNT_BITS   = 20;
  localparam int COIN_BITS     = 16;
  localparam int SLOT_BITS     = 3;
  localparam int USE_BITS      = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam int IN_DATA_BITS  = ((2 * AMOUNT_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((COIN_BITS + AMOUNT_BITS + 7) / 8) * 8;
  localparam int CNT_BITS      = $clog2(AMOUNT_BITS + 1);

  localparam logic [CFG_IDX_BITS-1:0] REG_COINS_IN_USE = CFG_IDX_BITS'(MAX_COINS);

  typedef struct packed {
    logic                   done;
    logic [AMOUNT_BITS-1:0] quo;
    logic [COIN_BITS-1:0]   rem;
  } div_res_t;

endpackage

FILE: src/gcchg_cfg.sv
// Denomination and coins-in-use registers with slot read mux.
module gcchg_cfg
  import gcchg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic [SLOT_BITS-1:0]     slot_i,
  output logic [COIN_BITS-1:0]     coin_o,
  output logic [USE_BITS-1:0]      used_o
);

  logic [COIN_BITS-1:0] coin_r [MAX_COINS];
  logic [USE_BITS-1:0]  use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_COINS; i++) begin
        coin_r[i] <= COIN_BITS'(1);
      end
      use_r <= USE_BITS'(1);
    end else if (cfg_we) begin
      if (cfg_idx < REG_COINS_IN_USE) begin
        coin_r[cfg_idx] <= cfg_wdata[COIN_BITS-1:0];
      end else if (cfg_idx == REG_COINS_IN_USE) begin
        use_r <= cfg_wdata[USE_BITS-1:0];
      end
    end
  end

  always_comb begin
    if (slot_i < SLOT_BITS'(MAX_COINS)) begin
      coin_o = coin_r[slot_i];
    end else begin
      coin_o = '0;
    end
    if (use_r == '0) begin
      used_o = USE_BITS'(1);
    end else if (use_r > USE_BITS'(MAX_COINS)) begin
      used_o = USE_BITS'(MAX_COINS);
    end else begin
      used_o = use_r;
    end
  end

endmodule

FILE: src/gcchg_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module gcchg_div
  import gcchg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start_i,
  input  logic [AMOUNT_BITS-1:0] dividend_i,
  input  logic [COIN_BITS-1:0]   divisor_i,
  output div_res_t               res_o
);

  logic [AMOUNT_BITS-1:0] quo_r;
  logic [COIN_BITS-1:0]   rem_r;
  logic [COIN_BITS-1:0]   div_r;
  logic [CNT_BITS-1:0]    cnt_r;
  logic                   busy_r;
  logic                   done_r;
  logic [COIN_BITS:0]     trial;
  logic [COIN_BITS:0]     diff;
  logic                   ge;

  assign trial = {rem_r, quo_r[AMOUNT_BITS-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(AMOUNT_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      quo_r <= dividend_i;
      rem_r <= '0;
      div_r <= divisor_i;
    end else if (busy_r) begin
      quo_r <= {quo_r[AMOUNT_BITS-2:0], ge};
      rem_r <= ge ? diff[COIN_BITS-1:0] : trial[COIN_BITS-1:0];
    end
  end

  assign res_o.done = done_r;
  assign res_o.quo  = quo_r;
  assign res_o.rem  = rem_r;

endmodule

FILE: src/greedy_coin_change_top.sv
// Greedy coin change top level: sequencer, output register, config registers and divider.
//
//   Channel  Ports                          Word
//   input    in_tvalid/in_tready/in_tdata   price, paid
//   result   out_tvalid/out_tready/...      coin_amount, coin_count; slot; last
//   config   cfg_we/cfg_idx/cfg_wdata       one register write per cycle
//
// Each slot in use runs through the bit-serial divider; a zero denomination
// skips the divider and gives a count of zero.
// Reset is synchronous; denominations return to 1 and coins in use to 1.
// A stalled result holds only the sequencer once the next slot is ready.
module greedy_coin_change_top
  import gcchg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // price, paid
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // coin_amount, coin_count, zero pad
  output logic [SLOT_BITS-1:0]     out_tuser,  // slot
  output logic                     out_tlast,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT, S_PUSH} state_t;

  state_t                 state_r, state_nxt;
  logic [SLOT_BITS-1:0]   slot_r, slot_nxt;
  logic [AMOUNT_BITS-1:0] change_r, change_nxt;
  logic [AMOUNT_BITS-1:0] count_r, count_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SLOT_BITS-1:0]   out_slot_r, out_slot_nxt;
  logic [COIN_BITS-1:0]   out_amount_r, out_amount_nxt;
  logic [AMOUNT_BITS-1:0] out_count_r, out_count_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [AMOUNT_BITS-1:0] price;
  logic [AMOUNT_BITS-1:0] paid;
  logic [COIN_BITS-1:0]   coin;
  logic [USE_BITS-1:0]    used;
  logic                   div_start;
  logic                   is_last;
  div_res_t               div_res;

  assign price = in_tdata[AMOUNT_BITS-1:0];
  assign paid  = in_tdata[2*AMOUNT_BITS-1:AMOUNT_BITS];

  gcchg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .slot_i    (slot_r),
    .coin_o    (coin),
    .used_o    (used)
  );

  assign div_start = (state_r == S_RUN) && (coin != '0);

  gcchg_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (change_r),
    .divisor_i  (coin),
    .res_o      (div_res)
  );

  assign in_tready = (state_r == S_IDLE);
  assign is_last   = (USE_BITS'(slot_r) + USE_BITS'(1)) == used;

  always_comb begin
    state_nxt      = state_r;
    slot_nxt       = slot_r;
    change_nxt     = change_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_slot_nxt   = out_slot_r;
    out_amount_nxt = out_amount_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          change_nxt = (paid >= price) ? (paid - price) : '0;
          slot_nxt   = '0;
          state_nxt  = S_RUN;
        end
      end
      S_RUN: begin
        if (coin == '0) begin
          count_nxt = '0;
          state_nxt = S_PUSH;
        end else begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (div_res.done) begin
          count_nxt  = div_res.quo;
          change_nxt = AMOUNT_BITS'(div_res.rem);
          state_nxt  = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = slot_r;
          out_amount_nxt = coin;
          out_count_nxt  = count_r;
          out_last_nxt   = is_last;
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            slot_nxt  = slot_r + SLOT_BITS'(1);
            state_nxt = S_RUN;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      slot_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      slot_r      <= slot_nxt;
    end
    change_r     <= change_nxt;
    count_r      <= count_nxt;
    out_slot_r   <= out_slot_nxt;
    out_amount_r <= out_amount_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_slot_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_DATA_BITS'({out_count_r, out_amount_r});

endmodule

FILE: src/gcchg_chk.sv
// Port-level checks for the greedy coin change top level, bound to it.
module gcchg_chk
  import gcchg_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_tvalid,
  input logic                     in_tready,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [OUT_DATA_BITS-1:0] out_tdata,
  input logic [SLOT_BITS-1:0]     out_tuser,
  input logic                     out_tlast
);

  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again while a word is in progress");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser < SLOT_BITS'(MAX_COINS))
    else $error("result slot out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result word changed");

endmodule

bind greedy_coin_change_top gcchg_chk u_chk (.*);

FILE: bench/tb.sv
// Testbench for greedy_coin_change_top: directed and random change requests checked word by word.
`timescale 1ns / 1ps
module tb;
  import gcchg_pkg::*;

  localparam int HOLD_CYCLES  = 700;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 200;
  localparam int PHASE_ITEMS  = 50;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE  = CFG_IDX_BITS'(7);
  localparam logic [AMOUNT_BITS-1:0]  AMOUNT_MAX = '1;

  typedef struct packed {
    logic [SLOT_BITS-1:0]   slot;
    logic [COIN_BITS-1:0]   amount;
    logic [AMOUNT_BITS-1:0] count;
    logic                   last;
  } coin_result_t;

  typedef logic [COIN_BITS-1:0] denom_set_t [MAX_COINS];

  typedef enum {DEN_SORTED, DEN_UNSORTED, DEN_WITH_ZERO, DEN_ALL_MAX, DEN_ALL_ONE} denom_mode_t;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata   = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic [SLOT_BITS-1:0]     out_tuser;
  logic                     out_tlast;
  logic                     cfg_we     = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx    = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata  = '0;

  logic [COIN_BITS-1:0] denom [MAX_COINS];
  logic [USE_BITS-1:0]  denom_used;
  coin_result_t         coin_due_q [$];
  int                   mismatches  = 0;
  int                   idle_cycles = 0;
  bit                   quiet       = 1'b0;
  bit                   hold_req    = 1'b0;
  bit                   hold_active = 1'b0;

  greedy_coin_change_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void predict_change(input logic [AMOUNT_BITS-1:0] price,
                                         input logic [AMOUNT_BITS-1:0] paid);
    logic [AMOUNT_BITS-1:0] rest;
    logic [AMOUNT_BITS-1:0] coin;
    coin_result_t           res;
    int                     used;
    int                     k;
    used = (denom_used == 0) ? 1 : ((denom_used > MAX_COINS) ? MAX_COINS : int'(denom_used));
    rest = (paid >= price) ? paid - price : '0;
    for (k = 0; k < used; k++) begin
      coin       = AMOUNT_BITS'(denom[k]);
      res.slot   = SLOT_BITS'(k);
      res.amount = denom[k];
      res.count  = '0;
      if (paid >= price && coin != 0 && rest >= coin) begin
        res.count = rest / coin;
        rest      = rest % coin;
      end
      res.last = (k == used - 1);
      coin_due_q.push_back(res);
    end
  endfunction

  task automatic send_item(input logic [AMOUNT_BITS-1:0] price,
                           input logic [AMOUNT_BITS-1:0] paid);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_BITS'({paid, price});
    do @(posedge clk); while (!in_tready);
    predict_change(price, paid);
  endtask

  task automatic send_random_item();
    logic [AMOUNT_BITS-1:0] price;
    logic [AMOUNT_BITS-1:0] paid;
    logic [AMOUNT_BITS-1:0] change;
    int                     roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      price = AMOUNT_BITS'($urandom_range(1, AMOUNT_MAX));
      paid  = AMOUNT_BITS'($urandom_range(0, price - 1));
    end else if (roll < 20) begin
      price = AMOUNT_BITS'($urandom);
      paid  = AMOUNT_BITS'($urandom);
    end else begin
      change = AMOUNT_BITS'($urandom_range(0, (1 << $urandom_range(0, AMOUNT_BITS)) - 1));
      price  = AMOUNT_BITS'($urandom_range(0, AMOUNT_MAX - change));
      paid   = price + change;
    end
    send_item(price, paid);
  endtask

  // drop valid and wait for every outstanding word
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (coin_due_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < MAX_COINS) denom[idx] = data[COIN_BITS-1:0];
    else if (idx == REG_COINS_IN_USE) denom_used = data[USE_BITS-1:0];
  endtask

  task automatic load_coins(input denom_set_t set, input logic [USE_BITS-1:0] used);
    int k;
    for (k = 0; k < MAX_COINS; k++) write_reg(CFG_IDX_BITS'(k), CFG_DATA_BITS'(set[k]));
    write_reg(REG_COINS_IN_USE, CFG_DATA_BITS'(used));
  endtask

  task automatic random_config(input denom_mode_t mode);
    int                  vals [$];
    denom_set_t          set;
    logic [USE_BITS-1:0] used;
    int                  k;
    for (k = 0; k < MAX_COINS; k++)
      vals.push_back($urandom_range(1, (1 << $urandom_range(1, COIN_BITS)) - 1));
    if (mode != DEN_UNSORTED) vals.rsort();
    for (k = 0; k < MAX_COINS; k++) set[k] = COIN_BITS'(vals[k]);
    case (mode)
      DEN_WITH_ZERO: set[$urandom_range(0, MAX_COINS - 1)] = '0;
      DEN_ALL_MAX:   set = '{default: '1};
      DEN_ALL_ONE:   set = '{default: COIN_BITS'(1)};
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) used = USE_BITS'(7 * $urandom_range(0, 1));
    else used = USE_BITS'($urandom_range(1, MAX_COINS));
    load_coins(set, used);
  endtask

  task automatic test_reset_values();
    send_item('0, '0);
    send_item('0, AMOUNT_MAX);
    send_item(AMOUNT_MAX, '0);
    send_item(20'd5, 20'd5);
    send_item(AMOUNT_MAX, AMOUNT_MAX);
    drain();
  endtask

  task automatic test_directed_change();
    load_coins('{16'd50000, 16'd10000, 16'd500, 16'd100, 16'd5, 16'd1}, USE_BITS'(6));
    send_item('0, AMOUNT_MAX);
    send_item(20'd300, 20'd200);
    send_item(20'd777, 20'd777);
    send_item(AMOUNT_MAX, AMOUNT_MAX);
    send_item('0, 20'd1);
    send_item(20'd12345, 20'd98765);
    drain();
    load_coins('{16'hFFFF, 16'd4096, 16'd255, 16'd16, 16'd3, 16'd1}, USE_BITS'(6));
    send_item('0, AMOUNT_MAX);
    send_item('0, 20'd65535);
    send_item('0, 20'd65534);
    drain();
    load_coins('{16'd100, 16'd0, 16'd10, 16'd0, 16'd1, 16'd0}, USE_BITS'(6));
    send_item('0, 20'd987);
    send_item(20'd5, 20'd4);
    drain();
    load_coins('{16'd1, 16'd5, 16'd100, 16'd7, 16'd50, 16'd3}, USE_BITS'(6));
    send_item('0, 20'd250);
    drain();
    load_coins('{16'd7, 16'd50, 16'd3, 16'd2, 16'd9, 16'd1}, USE_BITS'(6));
    send_item(20'd1000, 20'd1123);
    drain();
    write_reg(REG_COINS_IN_USE, '0);
    send_item(20'd10, 20'd31);
    drain();
    write_reg(REG_COINS_IN_USE, CFG_DATA_BITS'(7));
    send_item('0, 20'd4321);
    drain();
    write_reg(REG_SPARE, CFG_DATA_BITS'($urandom));
    write_reg(REG_COINS_IN_USE, 16'hFFFE);
    send_item(20'd77, 20'd54321);
    drain();
  endtask

  task automatic test_random_phases();
    denom_mode_t modes [8];
    int          phase;
    int          i;
    modes = '{DEN_SORTED, DEN_UNSORTED, DEN_WITH_ZERO, DEN_SORTED,
              DEN_ALL_MAX, DEN_ALL_ONE, DEN_WITH_ZERO, DEN_SORTED};
    for (phase = 0; phase < 8; phase++) begin
      random_config(modes[phase]);
      quiet = (phase == 3);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        send_random_item();
        if (i == PHASE_ITEMS / 2) drain();
      end
      drain();
      quiet = 1'b0;
    end
  endtask

  task automatic test_output_stall();
    int i;
    random_config(DEN_SORTED);
    write_reg(REG_COINS_IN_USE, CFG_DATA_BITS'(MAX_COINS));
    hold_req = 1'b1;
    while (!hold_active) @(posedge clk);
    quiet = 1'b1;
    for (i = 0; i < 10; i++) send_random_item();
    quiet = 1'b0;
    drain();
  endtask

  initial begin : rx_side
    int gap;
    forever begin
      @(posedge clk);
      gap      = hold_req ? HOLD_CYCLES : pick_gap();
      hold_req = 1'b0;
      if (gap > 0) begin
        out_tready  <= 1'b0;
        hold_active = (gap == HOLD_CYCLES);
        repeat (gap) @(posedge clk);
        hold_active = 1'b0;
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    coin_result_t got;
    coin_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.slot   = out_tuser;
      got.amount = out_tdata[COIN_BITS-1:0];
      got.count  = out_tdata[COIN_BITS+AMOUNT_BITS-1:COIN_BITS];
      got.last   = out_tlast;
      if (coin_due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: slot %0d amount %0d count %0d last %0d",
                   got.slot, got.amount, got.count, got.last);
      end else begin
        want = coin_due_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"word mismatch: expected slot %0d amount %0d count %0d last %0d,",
                      " got slot %0d amount %0d count %0d last %0d"},
                     want.slot, want.amount, want.count, want.last,
                     got.slot, got.amount, got.count, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("greedy_coin_change_top regression: fail");
      $finish;
    end
  end

  initial begin
    int k;
    for (k = 0; k < MAX_COINS; k++) denom[k] = COIN_BITS'(1);
    denom_used = USE_BITS'(1);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_directed_change();
    test_random_phases();
    test_output_stall();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (coin_due_q.size() != 0) begin
      mismatches++;
      $display("%0d expected words never arrived", coin_due_q.size());
    end
    if (mismatches == 0) begin
      $display("greedy_coin_change_top regression: pass");
    end else begin
      $display("greedy_coin_change_top regression: fail");
    end
    $finish;
  end

endmodule
